@@ rtl/mfpxc_pkg.sv @@
// Package for the message frame parser with xor check.
// Shared constants: field widths, beat widths and the default payload depth.
// No dependencies.
package mfpxc_pkg;

  // default payload store depth in bytes (legal range 1 to 64)
  localparam int unsigned MaxPayloadDef = 32;

  // received byte, length field, payload index and header half widths
  localparam int unsigned ByteW = 8;
  localparam int unsigned LenW  = 7;
  localparam int unsigned IdxW  = 6;
  localparam int unsigned HalfW = 16;

  // result beat: four header halves, length, index, byte, zero padding
  localparam int unsigned OutFieldW = 4 * HalfW + LenW + IdxW + ByteW;
  localparam int unsigned OutDataW  = ((OutFieldW + 7) / 8) * 8;

endpackage

@@ rtl/mfpxc_store.sv @@
// Payload byte store for the message frame parser with xor check.
// One write port, one read port with registered read data.
// Depends on mfpxc_pkg for the byte width.
module mfpxc_store #(
  parameter int unsigned Depth = mfpxc_pkg::MaxPayloadDef,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic                         clk_i,
  input  logic                         we_i,
  input  logic [AddrW-1:0]             waddr_i,
  input  logic [mfpxc_pkg::ByteW-1:0]  wdata_i,
  input  logic                         re_i,
  input  logic [AddrW-1:0]             raddr_i,
  output logic [mfpxc_pkg::ByteW-1:0]  rdata_o
);

  logic [mfpxc_pkg::ByteW-1:0] mem_q [Depth];
  logic [mfpxc_pkg::ByteW-1:0] rdata_q;

  // write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/message_frame_parser_xor_check.sv @@
// Top level of the message frame parser with xor check.
// Parses sync word, header, payload and checksum; replays good frames from the payload store.
// Depends on mfpxc_pkg and mfpxc_store.
//
//  channel   | signals                        | beat contents
//  ----------+--------------------------------+-----------------------------------------
//  s_axis    | tvalid tready tdata[7:0] tlast | rx_byte, end_of_chunk on tlast
//  m_axis    | tvalid tready tdata[87:0] tlast| header, length, index, byte; last on tlast
//  cfg       | cfg_we_i cfg_wdata_i[31:0]     | sync_word
//
// Parsing takes one received byte per cycle. After the checksum byte of a good
// frame the input stalls while the run is replayed from the payload store: each
// result beat is a store read, then a hold until m_axis_tready, and a frame of N
// payload bytes gives max(N,1) beats, all with the input stalled.
// Reset puts the parser in the sync hunt with the sync word cleared; the store
// needs no clearing since only bytes written in the current frame are read.
module message_frame_parser_xor_check #(
  parameter int unsigned MaxPayload = mfpxc_pkg::MaxPayloadDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // tdata: [7:0] rx_byte
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [mfpxc_pkg::ByteW-1:0]       s_axis_tdata,
  input  logic                              s_axis_tlast,
  // tdata: [15:0] packet_id, [31:16] dest_addr, [47:32] src_addr,
  //        [63:48] message_id, [70:64] payload_len, [76:71] payload_index,
  //        [84:77] payload_byte, [87:85] zero
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [mfpxc_pkg::OutDataW-1:0]    m_axis_tdata,
  output logic                              m_axis_tlast,
  input  logic                              cfg_we_i,
  input  logic [31:0]                       cfg_wdata_i
);

  localparam int unsigned AddrW  = (MaxPayload > 1) ? $clog2(MaxPayload) : 1;
  localparam logic [mfpxc_pkg::ByteW-1:0] MaxLen = mfpxc_pkg::ByteW'(MaxPayload);
  localparam int unsigned PadW   = mfpxc_pkg::OutDataW - mfpxc_pkg::OutFieldW;

  typedef enum logic [2:0] {
    P_HUNT, P_PKT, P_DEST, P_SRC, P_MSG, P_LEN, P_PAY, P_CHK
  } phase_e;

  typedef enum logic [1:0] {
    E_IDLE, E_READ, E_SHOW
  } emit_e;

  phase_e                         phase_q, phase_d;
  emit_e                          emit_q, emit_d;
  logic [31:0]                    sync_word_q;
  logic [31:0]                    shift_q, shift_d;
  logic                           half_q, half_d;
  logic [mfpxc_pkg::ByteW-1:0]    xor_q, xor_d;
  logic [mfpxc_pkg::LenW-1:0]     cnt_q, cnt_d;
  logic [mfpxc_pkg::LenW-1:0]     idx_q, idx_d;

  logic [mfpxc_pkg::HalfW-1:0]    pkt_id_q, dest_q, src_q, msg_id_q;
  logic [mfpxc_pkg::LenW-1:0]     len_q;

  logic [mfpxc_pkg::ByteW-1:0]    rx_byte;
  logic                           in_fire;
  logic [31:0]                    shift_nxt;
  logic [mfpxc_pkg::LenW-1:0]     cnt_inc;
  logic                           mem_we, mem_re;
  logic [mfpxc_pkg::ByteW-1:0]    mem_rdata;
  logic                           run_last;
  logic [mfpxc_pkg::ByteW-1:0]    out_byte;

  assign rx_byte       = s_axis_tdata;
  assign s_axis_tready = (emit_q == E_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign shift_nxt     = {shift_q[23:0], rx_byte};
  assign cnt_inc       = cnt_q + mfpxc_pkg::LenW'(1);

  // payload byte store
  mfpxc_store #(
    .Depth (MaxPayload),
    .AddrW (AddrW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (cnt_q[AddrW-1:0]),
    .wdata_i (rx_byte),
    .re_i    (mem_re),
    .raddr_i (idx_q[AddrW-1:0]),
    .rdata_o (mem_rdata)
  );

  // parser and replay next state
  always_comb begin
    phase_d = phase_q;
    emit_d  = emit_q;
    shift_d = shift_q;
    half_d  = half_q;
    xor_d   = xor_q;
    cnt_d   = cnt_q;
    idx_d   = idx_q;
    mem_we  = 1'b0;
    mem_re  = 1'b0;

    if (in_fire) begin
      if (phase_q != P_HUNT) begin
        xor_d = xor_q ^ rx_byte;
      end
      unique case (phase_q)
        P_HUNT: begin
          shift_d = shift_nxt;
          if (shift_nxt == sync_word_q) begin
            phase_d = P_PKT;
            shift_d = '0;
            half_d  = 1'b0;
            xor_d   = '0;
          end
        end
        P_PKT: begin
          half_d = ~half_q;
          if (half_q) phase_d = P_DEST;
        end
        P_DEST: begin
          half_d = ~half_q;
          if (half_q) phase_d = P_SRC;
        end
        P_SRC: begin
          half_d = ~half_q;
          if (half_q) phase_d = P_MSG;
        end
        P_MSG: begin
          half_d = ~half_q;
          if (half_q) phase_d = P_LEN;
        end
        P_LEN: begin
          if (rx_byte > MaxLen) begin
            phase_d = P_HUNT;
            shift_d = '0;
            half_d  = 1'b0;
          end else begin
            cnt_d   = '0;
            phase_d = (rx_byte == '0) ? P_CHK : P_PAY;
          end
        end
        P_PAY: begin
          mem_we = 1'b1;
          cnt_d  = cnt_inc;
          if (cnt_inc >= len_q) phase_d = P_CHK;
        end
        P_CHK: begin
          // good frame when the running xor folds to zero with the checksum
          if ((xor_q ^ rx_byte) == '0) begin
            emit_d = E_READ;
            idx_d  = '0;
          end
          phase_d = P_HUNT;
          shift_d = '0;
          half_d  = 1'b0;
        end
        default: phase_d = P_HUNT;
      endcase
      // end of chunk drops any partial frame
      if (s_axis_tlast) begin
        phase_d = P_HUNT;
        shift_d = '0;
        half_d  = 1'b0;
      end
    end

    // replay of a good frame, one store read per result beat
    unique case (emit_q)
      E_IDLE: ;
      E_READ: begin
        mem_re = 1'b1;
        emit_d = E_SHOW;
      end
      E_SHOW: begin
        if (m_axis_tready) begin
          if (run_last) begin
            emit_d = E_IDLE;
          end else begin
            idx_d  = idx_q + mfpxc_pkg::LenW'(1);
            emit_d = E_READ;
          end
        end
      end
      default: emit_d = E_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= P_HUNT;
      emit_q      <= E_IDLE;
      sync_word_q <= '0;
      shift_q     <= '0;
      half_q      <= 1'b0;
      xor_q       <= '0;
      cnt_q       <= '0;
      idx_q       <= '0;
    end else begin
      phase_q <= phase_d;
      emit_q  <= emit_d;
      shift_q <= shift_d;
      half_q  <= half_d;
      xor_q   <= xor_d;
      cnt_q   <= cnt_d;
      idx_q   <= idx_d;
      if (cfg_we_i) begin
        sync_word_q <= cfg_wdata_i;
      end
    end
  end

  // header fields, little-endian halves
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      case (phase_q)
        P_PKT: begin
          if (half_q) pkt_id_q[15:8] <= rx_byte;
          else        pkt_id_q[7:0]  <= rx_byte;
        end
        P_DEST: begin
          if (half_q) dest_q[15:8] <= rx_byte;
          else        dest_q[7:0]  <= rx_byte;
        end
        P_SRC: begin
          if (half_q) src_q[15:8] <= rx_byte;
          else        src_q[7:0]  <= rx_byte;
        end
        P_MSG: begin
          if (half_q) msg_id_q[15:8] <= rx_byte;
          else        msg_id_q[7:0]  <= rx_byte;
        end
        P_LEN: begin
          if (rx_byte <= MaxLen) len_q <= rx_byte[mfpxc_pkg::LenW-1:0];
        end
        default: ;
      endcase
    end
  end

  // result beat
  assign run_last      = (len_q == '0) || (idx_q == (len_q - mfpxc_pkg::LenW'(1)));
  assign out_byte      = (len_q == '0) ? '0 : mem_rdata;
  assign m_axis_tvalid = (emit_q == E_SHOW);
  assign m_axis_tlast  = run_last;
  assign m_axis_tdata  = {{PadW{1'b0}}, out_byte, idx_q[mfpxc_pkg::IdxW-1:0], len_q,
                          msg_id_q, src_q, dest_q, pkt_id_q};

endmodule

@@ tb/sv/tb_message_frame_parser_xor_check.sv @@
`timescale 1ns / 100ps
// Testbench for message_frame_parser_xor_check: byte stream in, frame result beats out.
// Self-checking against an in-bench frame parser; needs mfpxc_pkg, mfpxc_store and the top level.
module tb_message_frame_parser_xor_check;

  localparam int unsigned ByteW = mfpxc_pkg::ByteW;
  localparam int unsigned LenW = mfpxc_pkg::LenW;
  localparam int unsigned IdxW = mfpxc_pkg::IdxW;
  localparam int unsigned HalfW = mfpxc_pkg::HalfW;
  localparam int unsigned OutFieldW = mfpxc_pkg::OutFieldW;
  localparam int unsigned OutDataW = mfpxc_pkg::OutDataW;
  localparam int unsigned MaxPayload = mfpxc_pkg::MaxPayloadDef;
  localparam int CycleLimit = 500000;
  localparam int HoldCycles = 400;
  localparam int SettleCycles = 20;
  localparam int TailCycles = 60;

  typedef enum logic [2:0] {
    PH_HUNT, PH_PKT_ID, PH_DEST, PH_SRC, PH_MSG_ID, PH_LENGTH, PH_PAYLOAD, PH_CHECK
  } parse_phase_e;

  typedef enum int {FK_GOOD, FK_BAD_SUM, FK_OVERSIZE, FK_CUT, FK_EOC_END} frame_kind_e;

  typedef struct packed {
    logic [ByteW-1:0] b;
    logic             eoc;
  } rx_item_t;

  typedef struct {
    logic [HalfW-1:0] pid;
    logic [HalfW-1:0] dest;
    logic [HalfW-1:0] src;
    logic [HalfW-1:0] msg;
    logic [LenW-1:0]  len;
    logic [IdxW-1:0]  idx;
    logic [ByteW-1:0] pbyte;
    logic             last;
  } frame_beat_t;

  // clock, reset and block ports; the ones driven here are known from time zero
  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [ByteW-1:0]    s_tdata = '0;
  logic                s_tlast = 1'b0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [OutDataW-1:0] m_tdata;
  logic                m_tlast;
  logic                cfg_we = 1'b0;
  logic [31:0]         cfg_wdata = '0;

  // stimulus and checking bookkeeping
  rx_item_t    rx_backlog[$];
  frame_beat_t want_beats[$];
  int          n_pushed = 0;
  int          n_errors = 0;
  int          cycle_cnt = 0;
  int          tx_gap = 0;
  int          rx_stall = 0;
  bit          tx_idle = 1'b1;
  bit          rx_idle = 1'b1;
  bit          hold_go = 1'b0;
  bit          hold_done = 1'b0;

  // parser state of the bench copy
  logic [31:0]      sync_pat = '0;
  parse_phase_e     ph = PH_HUNT;
  logic [31:0]      hunt_shift = '0;
  bit               half_hi = 1'b0;
  logic [HalfW-1:0] hold_pid = '0;
  logic [HalfW-1:0] hold_dest = '0;
  logic [HalfW-1:0] hold_src = '0;
  logic [HalfW-1:0] hold_msg = '0;
  logic [7:0]       hold_len = '0;
  logic [6:0]       pay_cnt = '0;
  logic [7:0]       xor_acc = '0;
  logic [7:0]       pay_mem[MaxPayload];

  message_frame_parser_xor_check #(
    .MaxPayload(MaxPayload)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_tvalid),
    .s_axis_tready(s_tready),
    .s_axis_tdata (s_tdata),
    .s_axis_tlast (s_tlast),
    .m_axis_tvalid(m_tvalid),
    .m_axis_tready(m_tready),
    .m_axis_tdata (m_tdata),
    .m_axis_tlast (m_tlast),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata)
  );

  always #1 clk_i = ~clk_i;

  // ---------------------------------------------------------------- parser copy

  function automatic void go_hunt();
    ph = PH_HUNT;
    hunt_shift = '0;
    half_hi = 1'b0;
  endfunction

  // little-endian half assembly, half_hi back at zero once both bytes are in
  function automatic logic [HalfW-1:0] merge_half(input logic [HalfW-1:0] f,
                                                  input logic [7:0] b);
    if (!half_hi) begin
      half_hi = 1'b1;
      return {8'h00, b};
    end
    half_hi = 1'b0;
    return {b, f[7:0]};
  endfunction

  function automatic void parse_rx_byte(input rx_item_t it);
    frame_beat_t fb;
    int n;
    if (ph != PH_HUNT) xor_acc ^= it.b;
    case (ph)
      PH_HUNT: begin
        hunt_shift = {hunt_shift[23:0], it.b};
        if (hunt_shift == sync_pat) begin
          ph = PH_PKT_ID;
          hunt_shift = '0;
          half_hi = 1'b0;
          xor_acc = '0;
        end
      end
      PH_PKT_ID: begin
        hold_pid = merge_half(hold_pid, it.b);
        if (!half_hi) ph = PH_DEST;
      end
      PH_DEST: begin
        hold_dest = merge_half(hold_dest, it.b);
        if (!half_hi) ph = PH_SRC;
      end
      PH_SRC: begin
        hold_src = merge_half(hold_src, it.b);
        if (!half_hi) ph = PH_MSG_ID;
      end
      PH_MSG_ID: begin
        hold_msg = merge_half(hold_msg, it.b);
        if (!half_hi) ph = PH_LENGTH;
      end
      PH_LENGTH: begin
        if (it.b > MaxPayload) begin
          go_hunt();
        end else begin
          hold_len = it.b;
          pay_cnt = '0;
          ph = (it.b == 8'd0) ? PH_CHECK : PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        if (pay_cnt < MaxPayload) pay_mem[pay_cnt] = it.b;
        pay_cnt = pay_cnt + 7'd1;
        if (pay_cnt >= hold_len) ph = PH_CHECK;
      end
      default: begin
        // checksum byte: a zero running xor releases the whole run
        if (xor_acc == 8'd0) begin
          n = (hold_len == 8'd0) ? 1 : int'(hold_len);
          for (int k = 0; k < n; k++) begin
            fb.pid   = hold_pid;
            fb.dest  = hold_dest;
            fb.src   = hold_src;
            fb.msg   = hold_msg;
            fb.len   = hold_len[LenW-1:0];
            fb.idx   = IdxW'(k);
            fb.pbyte = (hold_len == 8'd0) ? 8'h00 : pay_mem[k];
            fb.last  = (k == n - 1);
            want_beats.push_back(fb);
          end
        end
        go_hunt();
      end
    endcase
    if (it.eoc) go_hunt();
  endfunction

  // ---------------------------------------------------------------- driver

  function automatic int pick_tx_gap();
    int r;
    if (!tx_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(12, 40);
  endfunction

  // accepted beats feed the parser copy, then the next byte goes out after its gap
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_tvalid && s_tready) parse_rx_byte('{b: s_tdata, eoc: s_tlast});
      if (!s_tvalid || s_tready) begin
        if (tx_gap > 0) begin
          tx_gap <= tx_gap - 1;
          s_tvalid <= 1'b0;
        end else if (rx_backlog.size() != 0) begin
          s_tdata  <= rx_backlog[0].b;
          s_tlast  <= rx_backlog[0].eoc;
          s_tvalid <= 1'b1;
          void'(rx_backlog.pop_front());
          tx_gap <= pick_tx_gap();
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- receiver

  // random stalls, plus one long hold-off so the input side backs up
  always @(posedge clk_i) begin
    if (hold_go && !hold_done) begin
      hold_done <= 1'b1;
      rx_stall  <= HoldCycles;
      m_tready  <= 1'b0;
    end else if (rx_stall > 0) begin
      rx_stall <= rx_stall - 1;
      m_tready <= 1'b0;
    end else if (!rx_idle || $urandom_range(0, 99) < 70) begin
      m_tready <= 1'b1;
    end else begin
      m_tready <= 1'b0;
      rx_stall <= ($urandom_range(0, 9) == 0) ? $urandom_range(12, 40) : $urandom_range(0, 2);
    end
  end

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    $display("%0t ns: mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    n_errors++;
  endtask

  // ---------------------------------------------------------------- monitor

  always @(posedge clk_i) begin
    frame_beat_t w;
    if (rst_ni && m_tvalid && m_tready) begin
      if (want_beats.size() == 0) begin
        report_mismatch("unexpected result beat", m_tdata[63:0], 0);
      end else begin
        w = want_beats.pop_front();
        if (m_tdata[15:0] !== w.pid) report_mismatch("packet_id", m_tdata[15:0], w.pid);
        if (m_tdata[31:16] !== w.dest) report_mismatch("dest_addr", m_tdata[31:16], w.dest);
        if (m_tdata[47:32] !== w.src) report_mismatch("src_addr", m_tdata[47:32], w.src);
        if (m_tdata[63:48] !== w.msg) report_mismatch("message_id", m_tdata[63:48], w.msg);
        if (m_tdata[70:64] !== w.len) report_mismatch("payload_len", m_tdata[70:64], w.len);
        if (m_tdata[76:71] !== w.idx)
          report_mismatch("payload_index", m_tdata[76:71], w.idx);
        if (m_tdata[84:77] !== w.pbyte)
          report_mismatch("payload_byte", m_tdata[84:77], w.pbyte);
        if (m_tlast !== w.last) report_mismatch("last", m_tlast, w.last);
        if (m_tdata[OutDataW-1:OutFieldW] !== '0)
          report_mismatch("tdata padding", m_tdata[OutDataW-1:OutFieldW], 0);
      end
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("tb_message_frame_parser_xor_check: FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------- stimulus

  task automatic push_rx(input logic [7:0] b, input logic eoc);
    rx_backlog.push_back('{b: b, eoc: eoc});
    n_pushed++;
  endtask

  function automatic logic [15:0] pick_half();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 16'h0000;
    if (r == 1) return 16'hFFFF;
    return 16'($urandom);
  endfunction

  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(0, 6);
    if (r < 95) return $urandom_range(7, MaxPayload - 1);
    return MaxPayload;
  endfunction

  // sync word, header, length, payload, checksum; kind decides how it is spoiled
  task automatic push_frame(input frame_kind_e kind, input int plen);
    logic [7:0]  body[$];
    logic [7:0]  sum;
    logic [15:0] h;
    int          cut;
    for (int f = 0; f < 4; f++) begin
      h = pick_half();
      body.push_back(h[7:0]);
      body.push_back(h[15:8]);
    end
    if (kind == FK_OVERSIZE) begin
      body.push_back(8'($urandom_range(MaxPayload + 1, 255)));
    end else begin
      body.push_back(8'(plen));
      for (int p = 0; p < plen; p++) body.push_back(8'($urandom));
      sum = '0;
      foreach (body[i]) sum ^= body[i];
      if (kind == FK_BAD_SUM) sum ^= 8'($urandom_range(1, 255));
      body.push_back(sum);
    end
    // an all-zero sync word already matches on a single zero byte
    if (sync_pat == '0) push_rx(8'h00, 1'b0);
    else for (int s = 3; s >= 0; s--) push_rx(sync_pat[8*s +: 8], 1'b0);
    cut = (kind == FK_CUT) ? $urandom_range(0, body.size() - 2) : -1;
    foreach (body[i]) begin
      if (cut < 0 || i <= cut)
        push_rx(body[i], (i == cut) || (kind == FK_EOC_END && i == body.size() - 1));
    end
  endtask

  // mostly well-formed frames, the rest spoiled frames and line noise
  task automatic gen_traffic(input int n_items);
    int start;
    int r;
    start = n_pushed;
    while (n_pushed - start < n_items) begin
      r = $urandom_range(0, 99);
      if (r < 55) push_frame(FK_GOOD, pick_len());
      else if (r < 65) push_frame(FK_BAD_SUM, pick_len());
      else if (r < 72) push_frame(FK_OVERSIZE, 0);
      else if (r < 80) push_frame(FK_CUT, pick_len());
      else if (r < 87) push_frame(FK_EOC_END, pick_len());
      else begin
        repeat ($urandom_range(1, 6)) push_rx(8'($urandom), $urandom_range(0, 19) == 0);
      end
    end
    // leave the parser hunting before the next sync word change
    push_rx(8'($urandom), 1'b1);
  endtask

  task automatic wait_drained();
    while (rx_backlog.size() != 0 || s_tvalid || want_beats.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_sync_word(input logic [31:0] w);
    repeat (SettleCycles) @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= w;
    sync_pat = w;
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed, sync word still at its reset value of zero:
    // empty payload with extreme header halves, then length one past the limit
    push_rx(8'h00, 1'b0);
    push_rx(8'hFF, 1'b0); push_rx(8'hFF, 1'b0);
    push_rx(8'h00, 1'b0); push_rx(8'h00, 1'b0);
    push_rx(8'hFF, 1'b0); push_rx(8'hFF, 1'b0);
    push_rx(8'h01, 1'b0); push_rx(8'h80, 1'b0);
    push_rx(8'h00, 1'b0);
    push_rx(8'h81, 1'b0);
    push_rx(8'h00, 1'b0);
    push_rx(8'h12, 1'b0); push_rx(8'h34, 1'b0);
    push_rx(8'h56, 1'b0); push_rx(8'h78, 1'b0);
    push_rx(8'h9A, 1'b0); push_rx(8'hBC, 1'b0);
    push_rx(8'hDE, 1'b0); push_rx(8'hF0, 1'b0);
    push_rx(8'(MaxPayload + 1), 1'b0);
    push_rx(8'hA5, 1'b0);
    push_rx(8'h5A, 1'b1);
    wait_drained();

    // all-ones sync word, long receiver hold-off behind a full-size frame
    set_sync_word(32'hFFFF_FFFF);
    push_frame(FK_GOOD, MaxPayload);
    push_frame(FK_GOOD, 1);
    gen_traffic(80);
    hold_go <= 1'b1;
    wait_drained();

    // random sync word, no idling on either side
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    set_sync_word($urandom);
    gen_traffic(90);
    wait_drained();

    // zero sync word written explicitly
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    set_sync_word(32'h0000_0000);
    gen_traffic(80);
    wait_drained();

    // random sync word again, idling back on
    set_sync_word($urandom);
    gen_traffic(90);
    wait_drained();

    repeat (TailCycles) @(posedge clk_i);
    if (n_errors == 0) begin
      $display("tb_message_frame_parser_xor_check: PASS");
    end else begin
      $display("tb_message_frame_parser_xor_check: FAIL");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/mfpxc_pkg.sv
rtl/mfpxc_store.sv
rtl/message_frame_parser_xor_check.sv
tb/sv/tb_message_frame_parser_xor_check.sv
